// ===== sv/hash_join_build_probe_defines.svh =====
// Assertion macros used by hash_join_build_probe.sv.
`ifndef HASH_JOIN_BUILD_PROBE_DEFINES_SVH
`define HASH_JOIN_BUILD_PROBE_DEFINES_SVH

`ifndef SYNTHESIS
`define HJBP_ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define HJBP_ASSERT(label, prop) \
   `HJBP_ASSERT_CLK(label, clock, reset, prop)
`else
`define HJBP_ASSERT_CLK(label, clk, rst, prop)
`define HJBP_ASSERT(label, prop)
`endif

`endif

// ===== sv/hjbp_pkg.sv =====
`default_nettype none
package hjbp_pkg;

   localparam int TableEntriesDefault = 64;
   localparam int FieldW              = 31;
   localparam int ReqDataW            = 64;
   localparam int RspDataW            = 128;

   localparam logic [1:0] CmdInsert = 2'd0;
   localparam logic [1:0] CmdProbe  = 2'd1;
   localparam logic [1:0] CmdClear  = 2'd2;

   localparam logic KindMatch  = 1'b0;
   localparam logic KindReject = 1'b1;

   typedef struct packed {
      logic write;    // store the insert tuple in this cell
      logic compare;  // latch the probe compare result
      logic active;   // cell lies below the fill count
      logic shift;    // take the neighbor's contents
   } cell_ctrl_type;

   typedef struct packed {
      logic [FieldW-1:0] key;
      logic [FieldW-1:0] value;
      logic              match;
   } cell_data_type;

endpackage
`default_nettype wire

// ===== sv/hjbp_cell.sv =====
`default_nettype none
module hjbp_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire hjbp_pkg::cell_ctrl_type       ctrl,
   input  wire logic [hjbp_pkg::FieldW-1:0]   wr_key,
   input  wire logic [hjbp_pkg::FieldW-1:0]   wr_value,
   input  wire logic [hjbp_pkg::FieldW-1:0]   probe_value,
   input  wire hjbp_pkg::cell_data_type       nb_in,
   output hjbp_pkg::cell_data_type            data_out
);

   logic [hjbp_pkg::FieldW-1:0] key_ff, key_in;
   logic [hjbp_pkg::FieldW-1:0] value_ff, value_in;
   logic                        match_ff, match_in;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      match_in = match_ff;
      if (ctrl.write) begin
         key_in   = wr_key;
         value_in = wr_value;
      end else if (ctrl.compare) begin
         match_in = ctrl.active && (value_ff == probe_value);
      end else if (ctrl.shift) begin
         key_in   = nb_in.key;
         value_in = nb_in.value;
         match_in = nb_in.match;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign data_out.key   = key_ff;
   assign data_out.value = value_ff;
   assign data_out.match = match_ff;

endmodule
`default_nettype wire

// ===== sv/hash_join_build_probe.sv =====
// Accepted inserts, clears and unused commands leave the controller in ST_IDLE; the next transaction
// follows at once. A rejected insert holds the input through ST_REJECT, plus any result stall.
// A probe rotates the whole cell ring once in ST_SCAN, one cell a cycle; the ring holds
// whenever a match at the head waits on a stalled result port.
// Results are registered: rsp_tvalid rises from the result register after a match or a reject.
// Reset clears the fill count, the match flags, the controller and the result valid;
// stored tuples are not cleared and only entries below the fill count are ever used.
`default_nettype none
`include "hash_join_build_probe_defines.svh"
module hash_join_build_probe #(
   parameter int TABLE_ENTRIES = hjbp_pkg::TableEntriesDefault
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // tuple_key[30:0], join_value[61:31], zeros
   input  wire logic [hjbp_pkg::ReqDataW-1:0]   req_tdata,
   // cmd[1:0]
   input  wire logic [1:0]                      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // probe_key[30:0], probe_value[61:31], build_key[92:62], build_value[123:93], zeros
   output logic [hjbp_pkg::RspDataW-1:0]        rsp_tdata,
   // kind[0]
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast
);

   localparam int FillW = $clog2(TABLE_ENTRIES + 1);
   localparam int CntW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int FW    = hjbp_pkg::FieldW;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_REJECT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [FillW-1:0] fill_ff, fill_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [FW-1:0]    pkey_ff, pkey_in;
   logic [FW-1:0]    pval_ff, pval_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [hjbp_pkg::RspDataW-1:0] rsp_data_ff, rsp_data_in;
   logic                          rsp_kind_ff, rsp_kind_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [1:0]  req_cmd;
   logic [FW-1:0] req_key, req_value;
   logic accept, full, out_free, shift, scan_emit, rej_emit, rest_any;
   logic [TABLE_ENTRIES-1:0] match_vec;

   hjbp_pkg::cell_data_type cell_q [TABLE_ENTRIES];
   hjbp_pkg::cell_data_type cell_nb [TABLE_ENTRIES];
   hjbp_pkg::cell_ctrl_type cell_ctrl [TABLE_ENTRIES];

   assign req_cmd   = req_tuser;
   assign req_key   = req_tdata[FW-1:0];
   assign req_value = req_tdata[2*FW-1:FW];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign full       = (fill_ff == FillW'(TABLE_ENTRIES));
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // hold the ring while a matching head waits for the result register
   assign shift     = (state_ff == ST_SCAN) && (!cell_q[0].match || out_free);
   assign scan_emit = (state_ff == ST_SCAN) && cell_q[0].match && out_free;
   assign rej_emit  = (state_ff == ST_REJECT) && out_free;

   generate
      for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
         if (i == TABLE_ENTRIES - 1) begin : g_wrap
            // head re-enters at the tail with its match flag dropped
            assign cell_nb[i].key   = cell_q[0].key;
            assign cell_nb[i].value = cell_q[0].value;
            assign cell_nb[i].match = 1'b0;
         end else begin : g_link
            assign cell_nb[i] = cell_q[i+1];
         end

         assign cell_ctrl[i].write   = accept && (req_cmd == hjbp_pkg::CmdInsert) &&
                                       (FillW'(i) == fill_ff);
         assign cell_ctrl[i].compare = accept && (req_cmd == hjbp_pkg::CmdProbe);
         assign cell_ctrl[i].active  = (FillW'(i) < fill_ff);
         assign cell_ctrl[i].shift   = shift;
         assign match_vec[i]         = cell_q[i].match;

         hjbp_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (cell_ctrl[i]),
            .wr_key      (req_key),
            .wr_value    (req_value),
            .probe_value (req_value),
            .nb_in       (cell_nb[i]),
            .data_out    (cell_q[i])
         );
      end
   endgenerate

   assign rest_any = ((match_vec >> 1) != '0);

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      pkey_in      = pkey_ff;
      pval_in      = pval_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pkey_in = req_key;
               pval_in = req_value;
               case (req_cmd)
                  hjbp_pkg::CmdInsert: begin
                     if (full) begin
                        state_in = ST_REJECT;
                     end else begin
                        fill_in = fill_ff + FillW'(1);
                     end
                  end
                  hjbp_pkg::CmdProbe: begin
                     state_in = ST_SCAN;
                     cnt_in   = '0;
                  end
                  hjbp_pkg::CmdClear: begin
                     fill_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (shift) begin
               cnt_in = cnt_ff + CntW'(1);
               if (cnt_ff == CntW'(TABLE_ENTRIES - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_REJECT: begin
            if (rej_emit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (scan_emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = hjbp_pkg::KindMatch;
         rsp_last_in  = !rest_any;
         rsp_data_in  = {{(hjbp_pkg::RspDataW - 4*FW){1'b0}},
                         cell_q[0].value, cell_q[0].key, pval_ff, pkey_ff};
      end else if (rej_emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = hjbp_pkg::KindReject;
         rsp_last_in  = 1'b1;
         rsp_data_in  = {{(hjbp_pkg::RspDataW - 2*FW){1'b0}}, pval_ff, pkey_ff};
      end
   end

   always_ff @(posedge clock) begin
      pkey_ff     <= pkey_in;
      pval_ff     <= pval_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   `HJBP_ASSERT(a_fill_bound, fill_ff <= FillW'(TABLE_ENTRIES))
   `HJBP_ASSERT(a_reject_last, rsp_tvalid && rsp_tuser |-> rsp_tlast)
   `HJBP_ASSERT(a_full_insert_rejects,
      accept && (req_cmd == hjbp_pkg::CmdInsert) && full |=> state_ff == ST_REJECT)
   `HJBP_ASSERT(a_head_waits,
      (state_ff == ST_SCAN) && cell_q[0].match && !out_free |-> !shift)

endmodule
`default_nettype wire
